// ===== rtl/lr_pkg.sv =====
package lr_pkg;

	// Coordinate width and the widths that follow from it.
	localparam int CW = 12;
	localparam int DW = CW + 1;
	localparam int EW = CW + 3;
	localparam int COLOR_W = 16;

	// Command queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	// One decoded command as it travels through the queue.
	typedef struct packed {
		op_t                  op;
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] y0;
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] ndy;
		logic                 sxn;
		logic                 syn;
		logic signed [EW-1:0] err;
		logic [COLOR_W-1:0]   color;
	} qent_t;

endpackage

// ===== rtl/lr_if.sv =====
// Input command channel.
interface lr_item_if;
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic signed [lr_pkg::CW-1:0] start_x;
	logic signed [lr_pkg::CW-1:0] start_y;
	logic signed [lr_pkg::CW-1:0] end_x;
	logic signed [lr_pkg::CW-1:0] end_y;
	logic [lr_pkg::COLOR_W-1:0]   color;

	modport source (output valid, opcode, start_x, start_y, end_x, end_y, color,
		input ready);
	modport sink (input valid, opcode, start_x, start_y, end_x, end_y, color,
		output ready);
endinterface

// Output pixel channel.
interface lr_pixel_if;
	logic                         valid;
	logic                         ready;
	logic signed [lr_pkg::CW-1:0] pixel_x;
	logic signed [lr_pkg::CW-1:0] pixel_y;
	logic [lr_pkg::COLOR_W-1:0]   pixel_color;
	logic                         last;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

// ===== rtl/lr_front.sv =====
module lr_front (
	lr_item_if.sink        items,
	input  logic           q_full,
	output logic           q_push,
	output lr_pkg::qent_t  q_wdata
);

	logic signed [lr_pkg::DW-1:0] x0_e;
	logic signed [lr_pkg::DW-1:0] y0_e;
	logic signed [lr_pkg::DW-1:0] x1_e;
	logic signed [lr_pkg::DW-1:0] y1_e;
	logic signed [lr_pkg::DW-1:0] dx_fwd;
	logic signed [lr_pkg::DW-1:0] dx_rev;
	logic signed [lr_pkg::DW-1:0] dy_fwd;
	logic signed [lr_pkg::DW-1:0] dy_rev;
	logic                         x_lt;
	logic                         y_lt;
	logic signed [lr_pkg::DW-1:0] dx;
	logic signed [lr_pkg::DW-1:0] ndy;

	// A transfer is taken whenever the queue has room.
	assign items.ready = !q_full;
	assign q_push      = items.valid && items.ready;

	// Both differences are formed in parallel, and the comparison picks the magnitude
	// for x and its negation for y, so no negation follows the subtraction.
	always_comb begin
		x0_e   = lr_pkg::DW'(items.start_x);
		y0_e   = lr_pkg::DW'(items.start_y);
		x1_e   = lr_pkg::DW'(items.end_x);
		y1_e   = lr_pkg::DW'(items.end_y);
		dx_fwd = x1_e - x0_e;
		dx_rev = x0_e - x1_e;
		dy_fwd = y1_e - y0_e;
		dy_rev = y0_e - y1_e;
		x_lt   = items.start_x < items.end_x;
		y_lt   = items.start_y < items.end_y;
		dx     = x_lt ? dx_fwd : dx_rev;
		ndy    = y_lt ? dy_rev : dy_fwd;
	end

	// Build the queue entry; a step command only needs its opcode.
	always_comb begin
		q_wdata.op    = lr_pkg::op_t'(items.opcode);
		q_wdata.x0    = items.start_x;
		q_wdata.y0    = items.start_y;
		q_wdata.x1    = items.end_x;
		q_wdata.y1    = items.end_y;
		q_wdata.dx    = dx;
		q_wdata.ndy   = ndy;
		q_wdata.sxn   = !x_lt;
		q_wdata.syn   = !y_lt;
		q_wdata.err   = lr_pkg::EW'(dx) + lr_pkg::EW'(ndy);
		q_wdata.color = items.color;
	end

endmodule

// ===== rtl/lr_queue.sv =====
module lr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lr_pkg::qent_t wdata,
	output logic          full,
	input  logic          pop,
	output lr_pkg::qent_t rdata,
	output logic          not_empty
);

	lr_pkg::qent_t              entries_q [lr_pkg::QDEPTH];
	logic [lr_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [lr_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [lr_pkg::QCNT_W-1:0]  count_q;

	assign full      = count_q == lr_pkg::QCNT_W'(lr_pkg::QDEPTH);
	assign not_empty = count_q != '0;
	assign rdata     = entries_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lr_pkg::QCNT_W'(lr_pkg::QDEPTH))
		else $error("command queue count above its depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("command queue popped while empty");

endmodule

// ===== rtl/lr_back.sv =====
module lr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  lr_pkg::qent_t q_data,
	output logic          q_pop,
	lr_pixel_if.source    pixels
);

	logic signed [lr_pkg::CW-1:0]  cur_x_q;
	logic signed [lr_pkg::CW-1:0]  cur_y_q;
	logic signed [lr_pkg::CW-1:0]  target_x_q;
	logic signed [lr_pkg::CW-1:0]  target_y_q;
	logic signed [lr_pkg::DW-1:0]  delta_x_q;
	logic signed [lr_pkg::DW-1:0]  neg_delta_y_q;
	logic                          step_x_neg_q;
	logic                          step_y_neg_q;
	logic signed [lr_pkg::EW-1:0]  error_term_q;
	logic [lr_pkg::COLOR_W-1:0]    line_color_q;
	logic                          active_q;

	logic                          out_valid_q;
	logic signed [lr_pkg::CW-1:0]  out_x_q;
	logic signed [lr_pkg::CW-1:0]  out_y_q;
	logic [lr_pkg::COLOR_W-1:0]    out_color_q;
	logic                          out_last_q;

	logic                          out_free;
	logic                          is_start;
	logic                          emit;
	logic                          at_end;
	logic signed [lr_pkg::EW:0]    e2;
	logic                          move_x;
	logic                          move_y;
	logic signed [lr_pkg::EW-1:0]  err_next;
	logic signed [lr_pkg::CW-1:0]  x_next;
	logic signed [lr_pkg::CW-1:0]  y_next;

	// Command dispatch: only a step with a pixel to show waits for the output.
	always_comb begin
		out_free = !out_valid_q || pixels.ready;
		is_start = q_data.op == lr_pkg::OP_START;
		emit     = q_valid && (q_data.op == lr_pkg::OP_STEP) && active_q;
		q_pop    = q_valid && (!emit || out_free);
	end

	// One Bresenham step: doubled error against both deltas.
	always_comb begin
		at_end   = (cur_x_q == target_x_q) && (cur_y_q == target_y_q);
		e2       = {error_term_q, 1'b0};
		move_x   = e2 >= (lr_pkg::EW+1)'(neg_delta_y_q);
		move_y   = e2 <= (lr_pkg::EW+1)'(delta_x_q);
		err_next = error_term_q
			+ (move_x ? lr_pkg::EW'(neg_delta_y_q) : lr_pkg::EW'(0))
			+ (move_y ? lr_pkg::EW'(delta_x_q) : lr_pkg::EW'(0));
		x_next   = cur_x_q;
		y_next   = cur_y_q;
		if (move_x) begin
			x_next = step_x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
		end
		if (move_y) begin
			y_next = step_y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop && is_start) begin
				active_q <= 1'b1;
			end else if (q_pop && emit && at_end) begin
				active_q <= 1'b0;
			end
			if (q_pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (pixels.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk state and output register.
	always_ff @(posedge clk) begin
		if (q_pop && is_start) begin
			cur_x_q       <= q_data.x0;
			cur_y_q       <= q_data.y0;
			target_x_q    <= q_data.x1;
			target_y_q    <= q_data.y1;
			delta_x_q     <= q_data.dx;
			neg_delta_y_q <= q_data.ndy;
			step_x_neg_q  <= q_data.sxn;
			step_y_neg_q  <= q_data.syn;
			error_term_q  <= q_data.err;
			line_color_q  <= q_data.color;
		end else if (q_pop && emit && !at_end) begin
			cur_x_q      <= x_next;
			cur_y_q      <= y_next;
			error_term_q <= err_next;
		end
		if (q_pop && emit) begin
			out_x_q     <= cur_x_q;
			out_y_q     <= cur_y_q;
			out_color_q <= line_color_q;
			out_last_q  <= at_end;
		end
	end

	assign pixels.valid       = out_valid_q;
	assign pixels.pixel_x     = out_x_q;
	assign pixels.pixel_y     = out_y_q;
	assign pixels.pixel_color = out_color_q;
	assign pixels.last        = out_last_q;

	a_end_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && emit && at_end) |=> (!active_q && pixels.valid && pixels.last))
		else $error("end point did not close the line");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && !q_pop) |-> (pixels.valid && !pixels.ready && active_q))
		else $error("command held without a blocked output");

endmodule

// ===== rtl/line_rasterizer_core.sv =====
// Bresenham line generator for all octants. A start command (opcode 0) loads
// both endpoints and a colour and produces no pixel; it drops any line still in
// progress. Each step command (opcode 1) produces the current pixel, with last
// set on the end point, after which the block is idle and further steps produce
// nothing. Commands are taken at one per cycle, while the four-entry command
// queue has room; the walker retires one command per cycle, start or step, while
// the pixel output is not held, so one pixel per cycle is sustained, set by the
// walker's error update. A step is written into the empty queue, and its pixel
// then into the output register; the queue only fills while output is held.
module line_rasterizer_core (
	input  logic       clk,
	input  logic       arst_n,
	lr_item_if.sink    items,
	lr_pixel_if.source pixels
);

	lr_pkg::qent_t q_wdata;
	lr_pkg::qent_t q_rdata;
	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;

	// Front: accepts commands and prepares deltas for a start.
	lr_front u_front (
		.items   (items),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	// Queue between front and walker.
	lr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.rdata     (q_rdata),
		.not_empty (q_valid)
	);

	// Back: walks the line and drives the pixel output register.
	lr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.pixels  (pixels)
	);

endmodule

// ===== bench/line_rasterizer_core_tb.sv =====
`timescale 1ns / 1ps

module line_rasterizer_core_tb;

	localparam int CMAX = 2 ** (lr_pkg::CW - 1) - 1;
	localparam int CMIN = -(2 ** (lr_pkg::CW - 1));
	localparam int CYCLE_LIMIT = 300000;
	localparam int ITEMS_PER_PHASE = 220;

	// One command as offered on the input channel.
	typedef struct packed {
		lr_pkg::op_t                  op;
		logic signed [lr_pkg::CW-1:0] x0;
		logic signed [lr_pkg::CW-1:0] y0;
		logic signed [lr_pkg::CW-1:0] x1;
		logic signed [lr_pkg::CW-1:0] y1;
		logic [lr_pkg::COLOR_W-1:0]   color;
	} cmd_t;

	// One pixel as seen on the output channel.
	typedef struct packed {
		logic signed [lr_pkg::CW-1:0] x;
		logic signed [lr_pkg::CW-1:0] y;
		logic [lr_pkg::COLOR_W-1:0]   color;
		logic                         last;
	} pixel_t;

	// How the expected outcome of a command is obtained.
	typedef enum logic [1:0] {
		K_PRED,
		K_NONE,
		K_PIXEL
	} outcome_t;

	typedef struct packed {
		outcome_t                     kind;
		lr_pkg::op_t                  op;
		logic signed [lr_pkg::CW-1:0] x0;
		logic signed [lr_pkg::CW-1:0] y0;
		logic signed [lr_pkg::CW-1:0] x1;
		logic signed [lr_pkg::CW-1:0] y1;
		logic [lr_pkg::COLOR_W-1:0]   color;
		logic signed [lr_pkg::CW-1:0] px;
		logic signed [lr_pkg::CW-1:0] py;
		logic [lr_pkg::COLOR_W-1:0]   pc;
		logic                         pl;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lr_item_if  items ();
	lr_pixel_if pixels ();

	line_rasterizer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.pixels (pixels)
	);

	// Directed commands: extremes, single-point lines, aborts and axis-aligned lines.
	dir_row_t dir_rows [0:24] = '{
		'{K_NONE, lr_pkg::OP_STEP, -1, -1, -1, -1, 16'hFFFF, 0, 0, 16'h0000, 1'b0},
		'{K_NONE, lr_pkg::OP_START, -2048, 2047, -2048, 2047, 16'hFFFF, 0, 0, 16'h0000, 1'b0},
		'{K_PIXEL, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, -2048, 2047, 16'hFFFF, 1'b1},
		'{K_NONE, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, 0, 0, 16'h0000, 1'b0},
		'{K_NONE, lr_pkg::OP_START, 2047, -2048, 2047, -2048, 16'h0000, 0, 0, 16'h0000, 1'b0},
		'{K_PIXEL, lr_pkg::OP_STEP, -1, -1, -1, -1, 16'hFFFF, 2047, -2048, 16'h0000, 1'b1},
		'{K_NONE, lr_pkg::OP_START, 0, 0, 3, 1, 16'h1234, 0, 0, 16'h0000, 1'b0},
		'{K_PIXEL, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, 0, 0, 16'h1234, 1'b0},
		'{K_PRED, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, 0, 0, 16'h0000, 1'b0},
		'{K_NONE, lr_pkg::OP_START, 5, 5, 2, 9, 16'hABCD, 0, 0, 16'h0000, 1'b0},
		'{K_PIXEL, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, 5, 5, 16'hABCD, 1'b0},
		'{K_PRED, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, 0, 0, 16'h0000, 1'b0},
		'{K_PRED, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, 0, 0, 16'h0000, 1'b0},
		'{K_PRED, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, 0, 0, 16'h0000, 1'b0},
		'{K_PRED, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, 0, 0, 16'h0000, 1'b0},
		'{K_NONE, lr_pkg::OP_START, 10, -3, 10, -7, 16'h5A5A, 0, 0, 16'h0000, 1'b0},
		'{K_PIXEL, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, 10, -3, 16'h5A5A, 1'b0},
		'{K_PRED, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, 0, 0, 16'h0000, 1'b0},
		'{K_PRED, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, 0, 0, 16'h0000, 1'b0},
		'{K_PRED, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, 0, 0, 16'h0000, 1'b0},
		'{K_PRED, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, 0, 0, 16'h0000, 1'b0},
		'{K_NONE, lr_pkg::OP_START, 7, 7, 5, 7, 16'h8000, 0, 0, 16'h0000, 1'b0},
		'{K_PIXEL, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, 7, 7, 16'h8000, 1'b0},
		'{K_PRED, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, 0, 0, 16'h0000, 1'b0},
		'{K_PRED, lr_pkg::OP_STEP, 0, 0, 0, 0, 16'h0000, 0, 0, 16'h0000, 1'b0}
	};

	// Line walker state mirrored from the block.
	logic signed [lr_pkg::CW-1:0] walk_x = '0;
	logic signed [lr_pkg::CW-1:0] walk_y = '0;
	logic signed [lr_pkg::CW-1:0] goal_x = '0;
	logic signed [lr_pkg::CW-1:0] goal_y = '0;
	logic signed [lr_pkg::DW-1:0] span_x = '0;
	logic signed [lr_pkg::DW-1:0] neg_span_y = '0;
	logic                         back_x = 1'b0;
	logic                         back_y = 1'b0;
	logic signed [lr_pkg::EW-1:0] err_acc = '0;
	logic [lr_pkg::COLOR_W-1:0]   walk_color = '0;
	logic                         walk_active = 1'b0;

	pixel_t pixels_due [$];
	int     mismatches = 0;
	int     items_done = 0;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	int     hold_left = 0;
	int     cycles = 0;
	event   hold_go;

	// Clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("line_rasterizer_core_tb: errors");
			$finish;
		end
	end

	// Long receiver hold-off, counted down one cycle at a time once requested.
	always begin : hold_timer
		@(hold_go);
		hold_left <= 400;
		repeat (400) begin
			@(posedge clk);
			hold_left <= hold_left - 1;
		end
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 50)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Works out the pixel, if any, that one accepted command produces.
	function automatic bit predict_pixel(input cmd_t c, output pixel_t p);
		int ddx;
		int ddy;
		int e2;
		p = '0;
		if (c.op == lr_pkg::OP_START) begin
			ddx = int'(c.x1) - int'(c.x0);
			ddy = int'(c.y1) - int'(c.y0);
			walk_x = c.x0;
			walk_y = c.y0;
			goal_x = c.x1;
			goal_y = c.y1;
			span_x = lr_pkg::DW'((ddx < 0) ? -ddx : ddx);
			neg_span_y = lr_pkg::DW'((ddy < 0) ? ddy : -ddy);
			back_x = !(c.x0 < c.x1);
			back_y = !(c.y0 < c.y1);
			err_acc = lr_pkg::EW'(span_x) + lr_pkg::EW'(neg_span_y);
			walk_color = c.color;
			walk_active = 1'b1;
			return 1'b0;
		end
		if (!walk_active)
			return 1'b0;
		p.x = walk_x;
		p.y = walk_y;
		p.color = walk_color;
		p.last = (walk_x == goal_x) && (walk_y == goal_y);
		if (p.last) begin
			walk_active = 1'b0;
		end else begin
			e2 = 2 * int'(err_acc);
			if (e2 >= int'(neg_span_y)) begin
				err_acc = err_acc + lr_pkg::EW'(neg_span_y);
				walk_x = back_x ? walk_x - lr_pkg::CW'(1) : walk_x + lr_pkg::CW'(1);
			end
			if (e2 <= int'(span_x)) begin
				err_acc = err_acc + lr_pkg::EW'(span_x);
				walk_y = back_y ? walk_y - lr_pkg::CW'(1) : walk_y + lr_pkg::CW'(1);
			end
		end
		return 1'b1;
	endfunction

	function automatic cmd_t random_cmd(input lr_pkg::op_t op);
		cmd_t c;
		c.op = op;
		c.x0 = lr_pkg::CW'($urandom);
		c.y0 = lr_pkg::CW'($urandom);
		c.x1 = lr_pkg::CW'($urandom);
		c.y1 = lr_pkg::CW'($urandom);
		c.color = lr_pkg::COLOR_W'($urandom);
		return c;
	endfunction

	// Offers one command until its transfer, then records what it should produce.
	// The valid stays high afterwards; whoever pauses next lowers it.
	task automatic send_item(input cmd_t c, input outcome_t kind, input pixel_t typed);
		pixel_t p;
		bit     made;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid <= 1'b1;
		items.opcode <= c.op;
		items.start_x <= c.x0;
		items.start_y <= c.y0;
		items.end_x <= c.x1;
		items.end_y <= c.y1;
		items.color <= c.color;
		@(posedge clk);
		while (!items.ready)
			@(posedge clk);
		made = predict_pixel(c, p);
		case (kind)
			K_PRED: begin
				if (made)
					pixels_due.push_back(p);
			end
			K_PIXEL: pixels_due.push_back(typed);
			default: ;
		endcase
		items_done++;
	endtask

	// A start followed by steps; mostly short lines walked to the end,
	// sometimes cut short, and a few long lines across the whole range abandoned early.
	task automatic line_scene();
		cmd_t c;
		int   r;
		int   span;
		int   ddx;
		int   ddy;
		int   xi;
		int   yi;
		int   steps;
		r = $urandom_range(99);
		c = random_cmd(lr_pkg::OP_START);
		if (r < 5) begin
			steps = $urandom_range(48, 4);
		end else begin
			span = (r < 15) ? 150 : 10;
			ddx = int'($urandom_range(2 * span)) - span;
			ddy = int'($urandom_range(2 * span)) - span;
			xi = int'(c.x0) + ddx;
			if (xi > CMAX || xi < CMIN)
				xi = int'(c.x0) - ddx;
			yi = int'(c.y0) + ddy;
			if (yi > CMAX || yi < CMIN)
				yi = int'(c.y0) - ddy;
			c.x1 = lr_pkg::CW'(xi);
			c.y1 = lr_pkg::CW'(yi);
			if (ddx < 0)
				ddx = -ddx;
			if (ddy < 0)
				ddy = -ddy;
			steps = ((ddx > ddy) ? ddx : ddy) + 1;
			if ($urandom_range(9) == 0)
				steps = $urandom_range(steps);
		end
		send_item(c, K_PRED, '0);
		repeat (steps)
			send_item(random_cmd(lr_pkg::OP_STEP), K_PRED, '0);
		// Occasional steps past the end of the line.
		if ($urandom_range(6) == 0)
			repeat ($urandom_range(2, 1))
				send_item(random_cmd(lr_pkg::OP_STEP), K_PRED, '0);
	endtask

	// A few commands of random kind and content.
	task automatic noise_scene();
		repeat ($urandom_range(4, 1))
			send_item(random_cmd(lr_pkg::op_t'($urandom_range(1))), K_PRED, '0);
	endtask

	// Output side: random back-pressure and checking of every pixel transfer.
	always @(posedge clk) begin : pixel_sink
		pixel_t got;
		pixel_t want;
		if (!arst_n) begin
			pixels.ready <= 1'b0;
		end else begin
			if (pixels.valid && pixels.ready) begin
				got = '{pixels.pixel_x, pixels.pixel_y, pixels.pixel_color, pixels.last};
				if (pixels_due.size() == 0) begin
					report_mismatch($sformatf("pixel (%0d,%0d) with nothing expected",
						got.x, got.y));
				end else begin
					want = pixels_due.pop_front();
					if (got.x !== want.x)
						report_mismatch($sformatf("pixel_x got %0d want %0d", got.x, want.x));
					if (got.y !== want.y)
						report_mismatch($sformatf("pixel_y got %0d want %0d", got.y, want.y));
					if (got.color !== want.color)
						report_mismatch($sformatf("pixel_color got %h want %h at (%0d,%0d)",
							got.color, want.color, want.x, want.y));
					if (got.last !== want.last)
						report_mismatch($sformatf("last got %b want %b at (%0d,%0d)",
							got.last, want.last, want.x, want.y));
				end
			end
			pixels.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Stimulus.
	initial begin
		cmd_t   c;
		pixel_t typed;
		items.valid <= 1'b0;
		items.opcode <= lr_pkg::OP_START;
		items.start_x <= '0;
		items.start_y <= '0;
		items.end_x <= '0;
		items.end_y <= '0;
		items.color <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (dir_rows[i]) begin
			c = '{dir_rows[i].op, dir_rows[i].x0, dir_rows[i].y0, dir_rows[i].x1,
				dir_rows[i].y1, dir_rows[i].color};
			typed = '{dir_rows[i].px, dir_rows[i].py, dir_rows[i].pc, dir_rows[i].pl};
			send_item(c, dir_rows[i].kind, typed);
		end
		items.valid <= 1'b0;
		do
			@(posedge clk);
		while (pixels_due.size() != 0);

		// Random phases with different idling on each side.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct = 64;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct <= 64;
				end
				default: begin
					send_idle_pct = 21;
					recv_stall_pct <= 21;
				end
			endcase
			if (ph == 0) begin
				// Long line with the output held off, so the command queue fills
				// and the input stalls.
				c = random_cmd(lr_pkg::OP_START);
				c.x0 = lr_pkg::CW'(-300);
				c.y0 = lr_pkg::CW'(100);
				c.x1 = lr_pkg::CW'(300);
				c.y1 = lr_pkg::CW'(-50);
				send_item(c, K_PRED, '0);
				-> hold_go;
				repeat (40)
					send_item(random_cmd(lr_pkg::OP_STEP), K_PRED, '0);
			end
			for (int target = items_done + ITEMS_PER_PHASE; items_done < target; ) begin
				if ($urandom_range(99) < 85)
					line_scene();
				else
					noise_scene();
			end
			// Sender pauses until every pixel has been delivered.
			items.valid <= 1'b0;
			do
				@(posedge clk);
			while (pixels_due.size() != 0);
		end

		recv_stall_pct <= 0;
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("line_rasterizer_core_tb: clean");
		else
			$display("line_rasterizer_core_tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/lr_pkg.sv
rtl/lr_if.sv
rtl/lr_front.sv
rtl/lr_queue.sv
rtl/lr_back.sv
rtl/line_rasterizer_core.sv
bench/line_rasterizer_core_tb.sv
